>>> hw/rtl/tmcp_pkg.sv
package tmcp_pkg;

    localparam int METRIC_W = 23;
    localparam logic [METRIC_W-1:0] METRIC_MAX = 23'h7FFFFF;
    localparam logic [5:0] NS_RESET = 6'd26;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [0:0] REG_NUM_STATES = 1'd0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  from_state;
        logic [4:0]  to_state;
        logic [15:0] table_value;
        logic [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [4:0]          symbol;
        logic [METRIC_W-1:0] path_cost;
        logic                last;
    } out_item_t;

endpackage

>>> hw/rtl/tmcp_ram.sv
module tmcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/trellis_min_cost_path_decoder_top.sv
// Trellis minimum-cost path decoder (Viterbi search, absolute-difference metric).
// Commands enter on in_item with start; a transaction is taken when start is
// high and busy is low. Load (cmd 0) writes one transition table entry. Sample
// (cmd 1) sweeps predecessors k = 0..n-1, one per cycle, and each cycle relaxes
// all destinations in parallel against that predecessor; the transition table
// is banked per destination so one read gives a full row. Finish (cmd 2) finds
// the least metric, traces back one step per backpointer RAM read (states
// ST_TRACE then ST_TWAIT for each step), then emits one symbol per ST_ERD and
// ST_EMIT pair on out_item with out_valid, last flagged.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Metrics live in flip-flops and are cleared by reset and after each finish.
// Table, backpointer and traceback memories are not cleared; num_states resets
// to 26. Register 0 (num_states) is written through the APB port at any address with paddr[2] low.
module trellis_min_cost_path_decoder_top
    import tmcp_pkg::*;
#(
    parameter int MAX_STATES  = 32,
    parameter int MAX_LEN     = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    in_item,
    output logic        out_valid,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = $clog2(MAX_STATES);
    localparam int LW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_STATES + 1);
    localparam int LCW = $clog2(MAX_LEN + 1);
    localparam logic [METRIC_W-1:0] SMASK = METRIC_W'((64'(1) << SAMPLE_BITS) - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_RELAX, ST_COMMIT, ST_FMIN, ST_TRACE, ST_TWAIT, ST_EMIT, ST_ERD
    } state_t;

    state_t state_reg;
    logic [5:0] num_states_reg;
    logic [CW-1:0] n_eff;
    logic [METRIC_W-1:0] metric_reg [MAX_STATES];
    logic [METRIC_W-1:0] next_reg [MAX_STATES];
    logic [SW-1:0] arg_reg [MAX_STATES];
    logic [CW-1:0] k_reg;
    logic          rd_valid_reg;
    logic [SW-1:0] rd_k_reg;
    logic [LCW-1:0] step_reg;
    logic [15:0] samp_reg;
    logic [SW-1:0] cur_reg;
    logic [METRIC_W-1:0] cost_reg;
    logic [LCW-1:0] idx_reg;

    logic accept;
    assign accept = start && !busy;
    assign busy = (state_reg != ST_IDLE);
    assign pready = 1'b1;
    assign prdata = {26'd0, num_states_reg};

    always_comb
    begin
        if (num_states_reg == 6'd0)
            n_eff = CW'(1);
        else if (32'(num_states_reg) > MAX_STATES)
            n_eff = CW'(MAX_STATES);
        else
            n_eff = CW'(num_states_reg);
    end

    // table banks: one per destination, addressed by predecessor
    logic load_ok;
    assign load_ok = accept && in_item.cmd == CMD_LOAD
        && 32'(in_item.from_state) < MAX_STATES && 32'(in_item.to_state) < MAX_STATES;
    logic [15:0] tab_rd [MAX_STATES];

    genvar g;
    generate
        for (g = 0; g < MAX_STATES; g++)
        begin : g_tab
            tmcp_ram #(.WIDTH(16), .DEPTH(MAX_STATES)) u_tab (
                .clk   (clk),
                .we    (load_ok && SW'(in_item.to_state) == SW'(g)),
                .waddr (SW'(in_item.from_state)),
                .wdata (in_item.table_value),
                .raddr (SW'(k_reg)),
                .rdata (tab_rd[g])
            );
        end
    endgenerate

    // backpointer RAM: one row per step; rather than bank-wise, rows are stored
    // whole as MAX_STATES*SW bits
    localparam int BPW = MAX_STATES * SW;
    logic [BPW-1:0] bp_wdata, bp_rdata;
    logic bp_we;
    logic [LW-1:0] bp_waddr, bp_raddr;
    always_comb
    begin
        // unused states point back to state 0
        for (int j = 0; j < MAX_STATES; j++)
            bp_wdata[j*SW +: SW] = (CW'(j) < n_eff) ? arg_reg[j] : '0;
    end
    assign bp_we = (state_reg == ST_COMMIT);
    assign bp_waddr = LW'(step_reg + LCW'(1));
    assign bp_raddr = LW'(idx_reg);

    tmcp_ram #(.WIDTH(BPW), .DEPTH(MAX_LEN)) u_bp (
        .clk(clk), .we(bp_we), .waddr(bp_waddr), .wdata(bp_wdata),
        .raddr(bp_raddr), .rdata(bp_rdata)
    );

    // traceback buffer
    logic tb_we;
    logic [SW-1:0] tb_rdata;
    assign tb_we = (state_reg == ST_TRACE);
    tmcp_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_tb (
        .clk(clk), .we(tb_we), .waddr(LW'(idx_reg)), .wdata(cur_reg),
        .raddr(LW'(idx_reg)), .rdata(tb_rdata)
    );

    // relax candidate for each destination against predecessor rd_k_reg
    logic [METRIC_W-1:0] cand [MAX_STATES];
    always_comb
    begin
        logic [16:0] d;
        logic [METRIC_W:0] s;
        for (int j = 0; j < MAX_STATES; j++)
        begin
            d = (samp_reg >= tab_rd[j]) ? 17'(samp_reg - tab_rd[j])
                                        : 17'(tab_rd[j] - samp_reg);
            s = (METRIC_W+1)'(metric_reg[rd_k_reg]) + (METRIC_W+1)'(d);
            cand[j] = s[METRIC_W] ? METRIC_MAX : s[METRIC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_states_reg <= NS_RESET;
            step_reg       <= '0;
            k_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            rd_k_reg       <= '0;
            samp_reg       <= '0;
            cur_reg        <= '0;
            cost_reg       <= '0;
            idx_reg        <= '0;
            out_valid      <= 1'b0;
            out_item       <= '0;
            for (int j = 0; j < MAX_STATES; j++)
            begin
                metric_reg[j] <= '0;
                next_reg[j]   <= '0;
                arg_reg[j]    <= '0;
            end
        end
        else
        begin
            out_valid <= 1'b0;
            if (psel && penable && pwrite && paddr[2] == REG_NUM_STATES)
                num_states_reg <= pwdata[5:0];
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && in_item.cmd == CMD_SAMPLE
                        && 32'(step_reg) < MAX_LEN - 1)
                    begin
                        samp_reg     <= 16'(METRIC_W'(in_item.sample) & SMASK);
                        k_reg        <= '0;
                        rd_valid_reg <= 1'b0;
                        state_reg    <= ST_RELAX;
                    end
                    else if (accept && in_item.cmd == CMD_FINISH)
                    begin
                        k_reg     <= CW'(1);
                        cur_reg   <= '0;
                        state_reg <= ST_FMIN;
                    end
                end
                ST_RELAX:
                begin
                    // issue table read for k_reg, relax on the one in flight
                    rd_valid_reg <= (k_reg < n_eff);
                    rd_k_reg     <= SW'(k_reg);
                    if (k_reg < n_eff)
                        k_reg <= k_reg + CW'(1);
                    if (rd_valid_reg)
                    begin
                        for (int j = 0; j < MAX_STATES; j++)
                        begin
                            if (rd_k_reg == '0 || cand[j] < next_reg[j])
                            begin
                                next_reg[j] <= cand[j];
                                arg_reg[j]  <= rd_k_reg;
                            end
                        end
                    end
                    else if (k_reg != '0)
                        state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    for (int j = 0; j < MAX_STATES; j++)
                    begin
                        if (CW'(j) < n_eff)
                            metric_reg[j] <= next_reg[j];
                        else
                        begin
                            metric_reg[j] <= METRIC_MAX;
                            arg_reg[j]    <= '0;
                        end
                    end
                    step_reg  <= step_reg + LCW'(1);
                    state_reg <= ST_IDLE;
                end
                ST_FMIN:
                begin
                    if (k_reg < n_eff)
                    begin
                        if (metric_reg[SW'(k_reg)] < metric_reg[cur_reg])
                            cur_reg <= SW'(k_reg);
                        k_reg <= k_reg + CW'(1);
                    end
                    else
                    begin
                        cost_reg  <= metric_reg[cur_reg];
                        idx_reg   <= step_reg;
                        state_reg <= ST_TRACE;
                    end
                end
                ST_TRACE:
                begin
                    // buffer written with cur at idx; bp row idx read
                    if (idx_reg == '0)
                    begin
                        state_reg <= ST_ERD;
                    end
                    else
                        state_reg <= ST_TWAIT;
                end
                ST_TWAIT:
                begin
                    cur_reg   <= bp_rdata[cur_reg*SW +: SW];
                    idx_reg   <= idx_reg - LCW'(1);
                    state_reg <= ST_TRACE;
                end
                ST_ERD:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    out_valid          <= 1'b1;
                    out_item.symbol    <= 5'(tb_rdata);
                    out_item.path_cost <= cost_reg;
                    out_item.last      <= (idx_reg == step_reg);
                    if (idx_reg == step_reg)
                    begin
                        for (int j = 0; j < MAX_STATES; j++)
                            metric_reg[j] <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + LCW'(1);
                        state_reg <= ST_ERD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last |-> state_reg == ST_IDLE)
        else $error("last result not followed by idle");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(step_reg) < MAX_LEN)
        else $error("step count overflow");
    a_commit_from_relax: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COMMIT |-> $past(state_reg) == ST_RELAX)
        else $error("commit without relax");

endmodule
